/* rtl/chm_pkg.sv */
// chm_pkg: shared widths, codes and helpers of the chained hash multiset
// no dependencies; imported by every module of the block
`default_nettype none

package chm_pkg;

   localparam int KEY_W    = 31;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 11;
   localparam int CFG_W    = 7;

   localparam int DEF_MAX_BUCKETS  = 64;
   localparam int DEF_BUCKET_DEPTH = 16;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // queue depth between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // modulo unit retires two dividend bits per cycle
   localparam int DIV_STEPS = (KEY_W + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // address bits for n entries, at least one
   function automatic int addr_bits(input int n);
      int r;
      r = (n > 1) ? $clog2(n) : 1;
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/chm_ram.sv */
// chm_ram: generic single write port, single read port ram with registered read
// uses chm_pkg for address width
`default_nettype none

module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = chm_pkg::addr_bits(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   import chm_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/chm_front.sv */
// chm_front: accepts transactions, holds the bucket count register and works out
// key modulo bucket count two bits a cycle; depends on chm_pkg
`default_nettype none

module chm_front #(
   parameter int MAX_BUCKETS = chm_pkg::DEF_MAX_BUCKETS,
   localparam int BKT_W   = chm_pkg::addr_bits(MAX_BUCKETS),
   localparam int ENTRY_W = chm_pkg::MODE_W + chm_pkg::KEY_W + BKT_W
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        enable,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [chm_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [chm_pkg::KEY_W-1:0]   req_key,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [chm_pkg::CFG_W-1:0]   csr_bucket_count,
   output logic                             push_valid,
   input  wire logic                        push_full,
   output logic      [ENTRY_W-1:0]          push_data
);
   import chm_pkg::*;

   localparam int CNT_W = addr_bits(DIV_STEPS);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CFG_W-1:0]  count_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [CFG_W-1:0]  rem_ff, rem_in;
   logic [CFG_W-1:0]  divisor_ff, divisor_in;
   logic [CFG_W-1:0]  divisor_sat;
   logic [CFG_W:0]    part_a, part_b;
   logic [CFG_W-1:0]  rem_a;
   logic              accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = !((state_ff == F_IDLE) && enable);
   assign accept     = req_valid && !req_stall;
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = {mode_ff, key_ff, BKT_W'(rem_ff)};

   // zero means one bucket, anything above the table size saturates
   always_comb begin
      divisor_sat = count_ff;
      if (count_ff == '0) begin
         divisor_sat = CFG_W'(1);
      end else if (int'(count_ff) > MAX_BUCKETS) begin
         divisor_sat = CFG_W'(MAX_BUCKETS);
      end
   end

   // two restoring steps on the remainder
   always_comb begin
      part_a = {rem_ff, div_ff[DIV_W-1]};
      if (part_a >= {1'b0, divisor_ff}) begin
         part_a = part_a - {1'b0, divisor_ff};
      end
      rem_a  = part_a[CFG_W-1:0];
      part_b = {rem_a, div_ff[DIV_W-2]};
      if (part_b >= {1'b0, divisor_ff}) begin
         part_b = part_b - {1'b0, divisor_ff};
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      mode_in    = mode_ff;
      key_in     = key_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               mode_in    = req_mode;
               key_in     = req_key;
               div_in     = DIV_W'(req_key);
               rem_in     = '0;
               cnt_in     = '0;
               divisor_in = divisor_sat;
               state_in   = F_DIV;
            end
         end
         F_DIV: begin
            rem_in = part_b[CFG_W-1:0];
            div_in = div_ff << 2;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!push_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= CFG_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_bucket_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      mode_ff    <= mode_in;
      key_ff     <= key_in;
      div_ff     <= div_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

endmodule

`default_nettype wire

/* rtl/chm_queue.sv */
// chm_queue: small fifo that decouples the front from the back
// depends on chm_pkg
`default_nettype none

module chm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = chm_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  not_empty
);
   import chm_pkg::*;

   localparam int PW = addr_bits(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/chm_back.sv */
// chm_back: carries out insert, check and read on the bucket memories and
// drives the result register; depends on chm_pkg and chm_ram
`default_nettype none

module chm_back #(
   parameter int MAX_BUCKETS  = chm_pkg::DEF_MAX_BUCKETS,
   parameter int BUCKET_DEPTH = chm_pkg::DEF_BUCKET_DEPTH,
   localparam int BKT_W   = chm_pkg::addr_bits(MAX_BUCKETS),
   localparam int ENTRY_W = chm_pkg::MODE_W + chm_pkg::KEY_W + BKT_W
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   output logic                               init_done,
   input  wire logic                          q_valid,
   input  wire logic [ENTRY_W-1:0]            q_data,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_found,
   output logic      [chm_pkg::KEY_W-1:0]     rsp_stored_key,
   output logic      [chm_pkg::STATUS_W-1:0]  rsp_status,
   output logic                               rsp_last,
   output logic      [chm_pkg::TOTAL_W-1:0]   rsp_total_count
);
   import chm_pkg::*;

   localparam int KEYS   = MAX_BUCKETS * BUCKET_DEPTH;
   localparam int KA_W   = addr_bits(KEYS);
   localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_FILL  = 2'd2;
   localparam logic [1:0] B_WALK  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [BKT_W-1:0]    clr_ff, clr_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [BKT_W-1:0]    bucket_ff, bucket_in;
   logic [KA_W-1:0]     base_ff, base_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   idx_ff, idx_in, idx_nxt;
   logic [KA_W-1:0]     key_addr_ff, key_addr_in;
   logic                found_ff, found_in;
   logic [KEY_W-1:0]    stored_ff, stored_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                last_ff, last_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;

   logic                out_free, last_entry;
   logic                emit, e_found, e_last;
   logic [KEY_W-1:0]    e_key;
   logic [STATUS_W-1:0] e_status;

   logic                fill_we;
   logic [BKT_W-1:0]    fill_wa;
   logic [FILL_W-1:0]   fill_wd, fill_rd;
   logic                key_we;
   logic [KA_W-1:0]     key_wa;
   logic [KEY_W-1:0]    key_rd;

   // read addresses follow the next register values so the registered read data lines up with the registers
   chm_ram #(.WIDTH(FILL_W), .DEPTH(MAX_BUCKETS)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_wa),
      .wr_data (fill_wd),
      .rd_addr (bucket_in),
      .rd_data (fill_rd)
   );

   chm_ram #(.WIDTH(KEY_W), .DEPTH(KEYS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_ff),
      .rd_addr (key_addr_in),
      .rd_data (key_rd)
   );

   assign init_done       = (state_ff != B_CLEAR);
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign idx_nxt         = idx_ff + FILL_W'(1);
   assign last_entry      = (idx_nxt == fill_ff);
   assign key_wa          = base_ff + KA_W'(fill_rd);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_stored_key  = stored_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;
   assign rsp_total_count = rsp_total_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      total_in     = total_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      bucket_in    = bucket_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      key_addr_in  = key_addr_ff;
      q_pop        = 1'b0;
      fill_we      = 1'b0;
      fill_wa      = bucket_ff;
      fill_wd      = '0;
      key_we       = 1'b0;
      emit         = 1'b0;
      e_found      = 1'b0;
      e_key        = '0;
      e_status     = STATUS_OK;
      e_last       = 1'b1;

      unique case (state_ff)
         B_CLEAR: begin
            fill_we = 1'b1;
            fill_wa = clr_ff;
            clr_in  = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(MAX_BUCKETS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               mode_in   = q_data[ENTRY_W-1 -: MODE_W];
               key_in    = q_data[BKT_W +: KEY_W];
               bucket_in = q_data[BKT_W-1:0];
               base_in   = KA_W'(q_data[BKT_W-1:0]) * KA_W'(BUCKET_DEPTH);
               state_in  = B_FILL;
            end
         end
         B_FILL: begin
            if (out_free) begin
               fill_in     = fill_rd;
               idx_in      = '0;
               key_addr_in = base_ff;
               state_in    = B_IDLE;
               unique case (mode_ff)
                  MODE_INSERT: begin
                     emit = 1'b1;
                     if (fill_rd >= FILL_W'(BUCKET_DEPTH)) begin
                        e_status = STATUS_FULL;
                     end else begin
                        key_we  = 1'b1;
                        fill_we = 1'b1;
                        fill_wd = fill_rd + FILL_W'(1);
                        if (total_ff != '1) begin
                           total_in = total_ff + TOTAL_W'(1);
                        end
                     end
                  end
                  MODE_CHECK: begin
                     if (fill_rd == '0) begin
                        emit = 1'b1;
                     end else begin
                        state_in = B_WALK;
                     end
                  end
                  MODE_READ: begin
                     if (fill_rd == '0) begin
                        emit     = 1'b1;
                        e_status = STATUS_EMPTY;
                     end else begin
                        state_in = B_WALK;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         B_WALK: begin
            if (out_free) begin
               if (mode_ff == MODE_CHECK) begin
                  if (key_rd == key_ff) begin
                     emit     = 1'b1;
                     e_found  = 1'b1;
                     state_in = B_IDLE;
                  end else if (last_entry) begin
                     emit     = 1'b1;
                     state_in = B_IDLE;
                  end else begin
                     idx_in      = idx_nxt;
                     key_addr_in = key_addr_ff + KA_W'(1);
                  end
               end else begin
                  emit   = 1'b1;
                  e_key  = key_rd;
                  e_last = last_entry;
                  if (last_entry) begin
                     state_in = B_IDLE;
                  end else begin
                     idx_in      = idx_nxt;
                     key_addr_in = key_addr_ff + KA_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // result register, freed when the consumer takes the transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      stored_in    = stored_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      rsp_total_in = rsp_total_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         found_in     = e_found;
         stored_in    = e_key;
         status_in    = e_status;
         last_in      = e_last;
         rsp_total_in = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      bucket_ff    <= bucket_in;
      base_ff      <= base_in;
      fill_ff      <= fill_in;
      idx_ff       <= idx_in;
      key_addr_ff  <= key_addr_in;
      found_ff     <= found_in;
      stored_ff    <= stored_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
      rsp_total_ff <= rsp_total_in;
   end

endmodule

`default_nettype wire

/* rtl/chained_hash_multiset.sv */
// chained_hash_multiset: top level; front (modulo), queue and back (bucket walk)
// front per transaction: accept, modulo steps, queue push, and only then the next one
// back reads the bucket fill for insert, and for check and read walks up to fill
// keys (at most BUCKET_DEPTH); reset clears the per-bucket fill counts in a pass
// over all buckets, nothing accepted meanwhile; bucket count resets to 64
`default_nettype none

module chained_hash_multiset #(
   parameter int MAX_BUCKETS  = chm_pkg::DEF_MAX_BUCKETS,
   parameter int BUCKET_DEPTH = chm_pkg::DEF_BUCKET_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [chm_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [chm_pkg::KEY_W-1:0]     req_key,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_found,
   output logic      [chm_pkg::KEY_W-1:0]     rsp_stored_key,
   output logic      [chm_pkg::STATUS_W-1:0]  rsp_status,
   output logic                               rsp_last,
   output logic      [chm_pkg::TOTAL_W-1:0]   rsp_total_count,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [chm_pkg::CFG_W-1:0]     csr_bucket_count
);
   import chm_pkg::*;

   localparam int BKT_W   = addr_bits(MAX_BUCKETS);
   localparam int ENTRY_W = MODE_W + KEY_W + BKT_W;

   logic               init_done;
   logic               push_valid, push_full;
   logic [ENTRY_W-1:0] push_data;
   logic               q_valid, q_pop;
   logic [ENTRY_W-1:0] q_data;

   chm_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .enable           (init_done),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bucket_count (csr_bucket_count),
      .push_valid       (push_valid),
      .push_full        (push_full),
      .push_data        (push_data)
   );

   chm_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (push_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_valid)
   );

   chm_back #(.MAX_BUCKETS(MAX_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .init_done       (init_done),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_stored_key  (rsp_stored_key),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .rsp_total_count (rsp_total_count)
   );

endmodule

`default_nettype wire
